>>> design/njs_pkg.sv
// njs_pkg: shared types and constants for the nearest four joint select block.
// Item structs for both channels, request codes and sequencer state codes.
// No dependencies.
package njs_pkg;

  localparam int DefMaxJoints    = 32;
  localparam int DefNearestCount = 4;
  localparam int OutFields       = 4;
  localparam int JointCountW     = 6;
  localparam int IndexW          = 5;
  localparam int CoordW          = 16;
  localparam int VertW           = CoordW + 1;   // vertex after the half offset
  localparam int DiffW           = CoordW + 2;
  localparam int SqW             = 34;           // |diff| < 2^17
  localparam int DistW           = 36;           // sum of three squares

  localparam logic [JointCountW-1:0] JointCountReset = JointCountW'(32);
  localparam logic signed [VertW-1:0] HalfQ12        = VertW'(2048);

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    req_t                     req_type;
    logic [IndexW-1:0]        joint_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] nearest_first;
    logic [IndexW-1:0] nearest_second;
    logic [IndexW-1:0] nearest_third;
    logic [IndexW-1:0] nearest_fourth;
  } out_item_t;

  // control from the sequencer to the ranking list
  typedef struct packed {
    logic clear;
    logic load;
  } rank_ctl_t;

endpackage

>>> design/nearest_four_joint_select_top.sv
// nearest_four_joint_select_top: four nearest joints to a vertex by brute force.
// Instantiates njs_dist (joint memory, distance pipeline) and njs_rank (sorted list).
// Depends on njs_pkg.
//
//  channel  | handshake          | payload            | notes
//  ---------+--------------------+--------------------+------------------------------
//  in       | in_valid/in_stall  | in_data (in_item_t)| write joint or query vertex
//  out      | out_valid/out_stall| out_data           | one item per query only
//  cfg      | cfg_wr_en          | cfg_wr_data        | joint_count, no read-back
//
// A query walks limit joints, with limit the joint count capped at MAX_JOINTS:
// one memory read per cycle feeds the single distance pipeline (3 stages), then the
// block drains the pipeline in ST_RUN and posts the result from ST_FIN.
// in_stall is high from a query's accept until its item is in the output register.
// The output register lets the block take new items while a result waits on
// out_stall; a second query finishing meanwhile holds until that slot is free.
// Reset is synchronous; joint_count resets to 32, joint memory is not cleared.
module nearest_four_joint_select_top #(
  parameter int MAX_JOINTS    = njs_pkg::DefMaxJoints,
  parameter int NEAREST_COUNT = njs_pkg::DefNearestCount
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  njs_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output njs_pkg::out_item_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [njs_pkg::JointCountW-1:0]   cfg_wr_data
);
  import njs_pkg::*;

  localparam int AW = $clog2(MAX_JOINTS);
  localparam int CW = (AW + 1 > JointCountW) ? AW + 1 : JointCountW;
  localparam int IW = (AW > IndexW) ? AW : IndexW;

  state_t state, state_next;

  logic [JointCountW-1:0] joint_count;
  logic [CW-1:0]          limit;
  logic [CW-1:0]          issue_cnt;
  logic [CW-1:0]          count_ext;
  logic [IW:0]            wr_idx_ext;

  logic signed [VertW-1:0] vx, vy, vz;

  logic      in_acc, wr_acc, q_acc, wr_ok;
  logic      rd_en, dist_vld, dist_busy, out_free;
  logic [DistW-1:0] dsq;
  logic [AW-1:0]    dist_idx;
  rank_ctl_t        rank_ctl;

  logic [NEAREST_COUNT-1:0][IndexW-1:0] pick;
  logic [OutFields-1:0][IndexW-1:0]     pick_pad;

  // input side handshake
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_acc   = in_acc && (in_data.req_type == REQ_WRITE);
  assign q_acc    = in_acc && (in_data.req_type == REQ_QUERY);

  // writes beyond the table are dropped
  assign wr_idx_ext = (IW + 1)'(in_data.joint_index);
  assign wr_ok      = wr_idx_ext < (IW + 1)'(MAX_JOINTS);

  assign count_ext = CW'(joint_count);
  assign rd_en     = (state == ST_RUN) && (issue_cnt < limit);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_acc) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (!rd_en && !dist_busy) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      joint_count <= JointCountReset;
      issue_cnt   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        joint_count <= cfg_wr_data;
      end
      if (q_acc) begin
        issue_cnt <= '0;
      end else if (rd_en) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // query context: vertex minus one half, search length capped to the table
  always_ff @(posedge clk) begin
    if (q_acc) begin
      vx    <= {in_data.coord_x[CoordW-1], in_data.coord_x} - HalfQ12;
      vy    <= {in_data.coord_y[CoordW-1], in_data.coord_y} - HalfQ12;
      vz    <= {in_data.coord_z[CoordW-1], in_data.coord_z} - HalfQ12;
      limit <= (count_ext > CW'(MAX_JOINTS)) ? CW'(MAX_JOINTS) : count_ext;
    end
  end

  njs_dist #(
    .MAX_JOINTS(MAX_JOINTS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_acc && wr_ok),
    .wr_addr  (wr_idx_ext[AW-1:0]),
    .wr_pos   ({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
    .rd_en    (rd_en),
    .rd_addr  (issue_cnt[AW-1:0]),
    .vx       (vx),
    .vy       (vy),
    .vz       (vz),
    .dist_vld (dist_vld),
    .dsq      (dsq),
    .dist_idx (dist_idx),
    .busy     (dist_busy)
  );

  assign rank_ctl.clear = q_acc;
  assign rank_ctl.load  = dist_vld;

  njs_rank #(
    .MAX_JOINTS   (MAX_JOINTS),
    .NEAREST_COUNT(NEAREST_COUNT)
  ) u_rank (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rank_ctl),
    .dsq  (dsq),
    .idx  (dist_idx),
    .pick (pick)
  );

  // slots past NEAREST_COUNT read as zero; extra slots are not shown
  for (genvar j = 0; j < OutFields; j++) begin : g_pad
    if (j < NEAREST_COUNT) begin : g_used
      assign pick_pad[j] = pick[j];
    end else begin : g_zero
      assign pick_pad[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_data.nearest_first  <= pick_pad[0];
      out_data.nearest_second <= pick_pad[1];
      out_data.nearest_third  <= pick_pad[2];
      out_data.nearest_fourth <= pick_pad[3];
    end
  end

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !dist_busy)
    else $error("distance pipeline busy while idle");

  a_post_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result posted outside finish state");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> issue_cnt <= limit)
    else $error("joint walk ran past the limit");

  a_dist_in_run: assert property (@(posedge clk) disable iff (rst)
    dist_vld |-> state == ST_RUN)
    else $error("distance arrived outside a query");
`endif

endmodule

>>> design/njs_dist.sv
// njs_dist: joint position memory and the squared distance pipeline.
// One joint read per cycle; the result passes the read, square and sum registers.
// Depends on njs_pkg.
module njs_dist #(
  parameter int MAX_JOINTS = njs_pkg::DefMaxJoints
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_JOINTS)-1:0]     wr_addr,
  input  logic [3*njs_pkg::CoordW-1:0]      wr_pos,
  input  logic                              rd_en,
  input  logic [$clog2(MAX_JOINTS)-1:0]     rd_addr,
  input  logic signed [njs_pkg::VertW-1:0]  vx,
  input  logic signed [njs_pkg::VertW-1:0]  vy,
  input  logic signed [njs_pkg::VertW-1:0]  vz,
  output logic                              dist_vld,
  output logic [njs_pkg::DistW-1:0]         dsq,
  output logic [$clog2(MAX_JOINTS)-1:0]     dist_idx,
  output logic                              busy
);
  import njs_pkg::*;

  localparam int AW = $clog2(MAX_JOINTS);

  logic [3*CoordW-1:0] mem [MAX_JOINTS];

  logic [3*CoordW-1:0] rd_q;
  logic                s0_vld, s1_vld;
  logic [AW-1:0]       s0_idx, s1_idx;
  logic [SqW-1:0]      sq_x, sq_y, sq_z;

  logic signed [CoordW-1:0] jx, jy, jz;
  logic signed [DiffW-1:0]  dx, dy, dz;
  logic signed [2*DiffW-1:0] px, py, pz;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_pos;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign jx = rd_q[3*CoordW-1:2*CoordW];
  assign jy = rd_q[2*CoordW-1:CoordW];
  assign jz = rd_q[CoordW-1:0];

  assign dx = {vx[VertW-1], vx} - {{2{jx[CoordW-1]}}, jx};
  assign dy = {vy[VertW-1], vy} - {{2{jy[CoordW-1]}}, jy};
  assign dz = {vz[VertW-1], vz} - {{2{jz[CoordW-1]}}, jz};

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld   <= 1'b0;
      s1_vld   <= 1'b0;
      dist_vld <= 1'b0;
    end else begin
      s0_vld   <= rd_en;
      s1_vld   <= s0_vld;
      dist_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s0_idx   <= rd_addr;
    s1_idx   <= s0_idx;
    dist_idx <= s1_idx;
    sq_x     <= px[SqW-1:0];
    sq_y     <= py[SqW-1:0];
    sq_z     <= pz[SqW-1:0];
    dsq      <= DistW'(sq_x) + DistW'(sq_y) + DistW'(sq_z);
  end

  assign busy = s0_vld || s1_vld || dist_vld;

endmodule

>>> design/njs_rank.sv
// njs_rank: sorted list of the nearest joints, filled by insertion.
// Strict less-than: an earlier joint keeps its place on a tie.
// Depends on njs_pkg.
module njs_rank #(
  parameter int MAX_JOINTS    = njs_pkg::DefMaxJoints,
  parameter int NEAREST_COUNT = njs_pkg::DefNearestCount
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  njs_pkg::rank_ctl_t                            ctl,
  input  logic [njs_pkg::DistW-1:0]                     dsq,
  input  logic [$clog2(MAX_JOINTS)-1:0]                 idx,
  output logic [NEAREST_COUNT-1:0][njs_pkg::IndexW-1:0] pick
);
  import njs_pkg::*;

  localparam int AW = $clog2(MAX_JOINTS);
  localparam int IW = (AW > IndexW) ? AW : IndexW;

  logic [DistW-1:0]         slot_dist [NEAREST_COUNT];
  logic [AW-1:0]            slot_idx  [NEAREST_COUNT];
  logic [NEAREST_COUNT-1:0] slot_vld;
  logic [NEAREST_COUNT-1:0] hit;

  // hit is a suffix mask: the list is sorted and filled from the front
  always_comb begin
    for (int j = 0; j < NEAREST_COUNT; j++) begin
      hit[j] = !slot_vld[j] || (dsq < slot_dist[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      slot_vld <= '0;
    end else if (ctl.load) begin
      for (int j = 0; j < NEAREST_COUNT; j++) begin
        if (hit[j]) begin
          if (j == 0 || !hit[(j == 0) ? 0 : j - 1]) begin
            slot_vld[j] <= 1'b1;
          end else begin
            slot_vld[j] <= slot_vld[(j == 0) ? 0 : j - 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int j = 0; j < NEAREST_COUNT; j++) begin
        if (hit[j]) begin
          if (j == 0 || !hit[(j == 0) ? 0 : j - 1]) begin
            slot_dist[j] <= dsq;
            slot_idx[j]  <= idx;
          end else begin
            slot_dist[j] <= slot_dist[(j == 0) ? 0 : j - 1];
            slot_idx[j]  <= slot_idx[(j == 0) ? 0 : j - 1];
          end
        end
      end
    end
  end

  always_comb begin
    logic [IW-1:0] wide;
    for (int j = 0; j < NEAREST_COUNT; j++) begin
      wide    = IW'(slot_idx[j]);
      pick[j] = slot_vld[j] ? wide[IndexW-1:0] : '0;
    end
  end

endmodule

>>> bench/testbench.sv
// testbench: self-checking bench for nearest_four_joint_select_top (joint table, 4-NN query).
// Predicts each query's four nearest joint indices from a local joint table and checks them.
// Depends on njs_pkg and the design sources.
`timescale 1ns / 100ps

module testbench;
  import njs_pkg::*;

  localparam int TableSize   = DefMaxJoints;
  localparam int NearestKept = DefNearestCount;
  localparam int LongHold    = 400;   // receiver hold-off that fills the block
  localparam int DrainCycles = 48;    // idle wait after draining; outlasts the longest query
  localparam int QuietLimit  = 2000;  // cycles with no item moving on the in or out channel
  localparam int PhaseItems  = 205;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // every input is known from time zero
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  in_item_t               in_data     = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  out_item_t              out_data;
  logic                   cfg_wr_en   = 1'b0;
  logic [JointCountW-1:0] cfg_wr_data = '0;

  nearest_four_joint_select_top DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Local copy of the joint table and the joint count register.
  logic signed [CoordW-1:0] joint_x [TableSize];
  logic signed [CoordW-1:0] joint_y [TableSize];
  logic signed [CoordW-1:0] joint_z [TableSize];
  int joint_limit = 32;

  in_item_t  item_backlog [$];   // items not yet offered to the block
  out_item_t nearest_due  [$];   // nearest-joint sets still owed by the block
  logic [TableSize-1:0] seeded = '0;  // entries written so far, in stimulus order

  bit idle_on   = 1'b1;   // random idling on both sides
  bit hold_flag = 1'b0;   // toggled to start one long receiver hold-off

  int mismatches  = 0;
  int items_in    = 0;
  int writes_in   = 0;
  int results_got = 0;

  // Store a joint, or rank the active joints by squared distance to the
  // vertex (shifted by one half) and queue the four nearest indices.
  function automatic void take_item(input in_item_t it);
    longint dx, dy, dz, dsq, vx, vy, vz;
    longint best_d [NearestKept];
    logic [IndexW-1:0] best_i [NearestKept];
    int filled, n, last;
    bit placed;
    out_item_t res;
    items_in++;
    if (it.req_type == REQ_WRITE) begin
      joint_x[it.joint_index] = it.coord_x;
      joint_y[it.joint_index] = it.coord_y;
      joint_z[it.joint_index] = it.coord_z;
      writes_in++;
      return;
    end
    vx = longint'($signed(it.coord_x)) - 2048;
    vy = longint'($signed(it.coord_y)) - 2048;
    vz = longint'($signed(it.coord_z)) - 2048;
    n = (joint_limit > TableSize) ? TableSize : joint_limit;
    filled = 0;
    for (int k = 0; k < NearestKept; k++) begin
      best_d[k] = 0;
      best_i[k] = '0;
    end
    for (int i = 0; i < n; i++) begin
      dx = vx - longint'($signed(joint_x[i]));
      dy = vy - longint'($signed(joint_y[i]));
      dz = vz - longint'($signed(joint_z[i]));
      dsq = dx * dx + dy * dy + dz * dz;
      placed = 1'b0;
      // strict less-than: an earlier joint keeps its slot on a tie
      for (int j = 0; j < NearestKept; j++) begin
        if (!placed && (j >= filled || dsq < best_d[j])) begin
          last = (filled < NearestKept) ? filled : NearestKept - 1;
          for (int k = last; k > j; k--) begin
            best_d[k] = best_d[k-1];
            best_i[k] = best_i[k-1];
          end
          best_d[j] = dsq;
          best_i[j] = IndexW'(i);
          if (filled < NearestKept) filled++;
          placed = 1'b1;
        end
      end
    end
    // slots no joint reached stay 0
    res.nearest_first  = best_i[0];
    res.nearest_second = best_i[1];
    res.nearest_third  = best_i[2];
    res.nearest_fourth = best_i[3];
    nearest_due.push_back(res);
  endfunction

  function automatic void check_field(string fname, logic [IndexW-1:0] want,
                                      logic [IndexW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  function automatic in_item_t make_item(req_t kind, int idx, int x, int y, int z);
    in_item_t it;
    it.req_type    = kind;
    it.joint_index = IndexW'(idx);
    it.coord_x     = CoordW'(x);
    it.coord_y     = CoordW'(y);
    it.coord_z     = CoordW'(z);
    return it;
  endfunction

  // Mix of corner values, a coarse grid (gives exact ties and zero
  // distances) and full-range noise.
  function automatic int pick_coord();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      case ($urandom_range(0, 5))
        0: return -32768;
        1: return 32767;
        2: return 0;
        3: return -1;
        4: return 2048;
        default: return -2048;
      endcase
    end else if (sel <= 3) begin
      return int'($urandom_range(0, 8)) * 1024 - 4096;
    end
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic post_item(input in_item_t it);
    if (it.req_type == REQ_WRITE) seeded[it.joint_index] = 1'b1;
    item_backlog.push_back(it);
  endtask

  // Random writes and queries; any entry a query would search that was never
  // written gets a write first.
  task automatic add_random_items(int count);
    int lim, idx;
    lim = (joint_limit > TableSize) ? TableSize : joint_limit;
    for (int c = 0; c < count; c++) begin
      if ($urandom_range(0, 1) == 1) begin
        for (int e = 0; e < lim; e++) begin
          if (!seeded[e]) post_item(make_item(REQ_WRITE, e, pick_coord(), pick_coord(),
                                              pick_coord()));
        end
        // joint_index is don't-care on a query; keep it random
        post_item(make_item(REQ_QUERY, $urandom_range(0, 31), pick_coord(), pick_coord(),
                            pick_coord()));
      end else begin
        if (lim > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, lim - 1);
        else idx = $urandom_range(0, TableSize - 1);
        post_item(make_item(REQ_WRITE, idx, pick_coord(), pick_coord(), pick_coord()));
      end
    end
  endtask

  // Sender pauses here until every owed result is back, then lets a
  // trailing write settle before anything else happens.
  task automatic wait_drained();
    @(negedge clk);
    while (item_backlog.size() != 0 || in_valid || nearest_due.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_joint_count(int value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= JointCountW'(value);
    joint_limit = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: offers the backlog in order, predicts on each accepted item.
  // A gap is picked when an item goes out and starts after it is taken.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) take_item(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          in_data  <= item_backlog.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest owed set and
  // drives out_stall (short random bursts, plus one long hold-off on request).
  int stall_left = 0;
  bit hold_seen  = 1'b0;
  out_item_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (nearest_due.size() == 0) begin
          $display("%0t: result with none owed, expected nothing, got %h", $time, out_data);
          mismatches++;
        end else begin
          want = nearest_due.pop_front();
          check_field("nearest_first",  want.nearest_first,  out_data.nearest_first);
          check_field("nearest_second", want.nearest_second, out_data.nearest_second);
          check_field("nearest_third",  want.nearest_third,  out_data.nearest_third);
          check_field("nearest_fourth", want.nearest_fourth, out_data.nearest_fourth);
          results_got++;
        end
      end
      if (hold_flag != hold_seen) begin
        hold_seen  = hold_flag;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);   // start a random stall burst
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if no item moves on either channel for too long.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, QuietLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Joint counts for the random phases: reset value, the lowest, the
  // 6-bit maximum (searches only the table), small and mid values.
  int phase_counts [8] = '{32, 1, 63, 2, 17, 33, 5, 32};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero joint count: nothing searched, all four outputs 0. No entry is
    // read, so the unwritten table is safe here.
    set_joint_count(0);
    post_item(make_item(REQ_QUERY, 0, 0, 0, 0));
    post_item(make_item(REQ_QUERY, 31, 32767, -32768, -1));
    wait_drained();

    // Three joints: the fourth slot is never filled. Joints 1 and 2 share a
    // position, so the lower index must win. Extremes stretch the
    // difference past 16 bits.
    set_joint_count(3);
    post_item(make_item(REQ_WRITE, 0, -32768, -32768, -32768));
    post_item(make_item(REQ_WRITE, 1, 32767, 32767, 32767));
    post_item(make_item(REQ_WRITE, 2, 32767, 32767, 32767));
    post_item(make_item(REQ_QUERY, 0, -32768, -32768, -32768));
    post_item(make_item(REQ_QUERY, 0, 32767, 32767, 32767));
    post_item(make_item(REQ_QUERY, 0, 2048, 2048, 2048));
    wait_drained();

    // Six joints: exact hits (vertex minus half lands on a joint), a tie at
    // zero distance, insertion that pushes entries down, and a write to index 31.
    set_joint_count(6);
    post_item(make_item(REQ_WRITE, 3, 0, 0, 0));
    post_item(make_item(REQ_WRITE, 4, -2048, 4096, 0));
    post_item(make_item(REQ_WRITE, 5, 0, 0, 0));
    post_item(make_item(REQ_WRITE, 31, -21846, 21845, -1));
    post_item(make_item(REQ_QUERY, 0, 2048, 2048, 2048));
    post_item(make_item(REQ_QUERY, 0, 0, 6144, 2048));
    post_item(make_item(REQ_QUERY, 0, -32768, 32767, 0));
    wait_drained();

    // Random phases. Each ends with the sender paused until all results are
    // back, so the register is only written while the block is idle.
    foreach (phase_counts[p]) begin
      set_joint_count(phase_counts[p]);
      idle_on = (p != $size(phase_counts) - 1);   // no idling in the last phase
      add_random_items(PhaseItems);
      // first phase: hold the output long enough that a second query
      // finishes behind the first and the input side backs up
      if (p == 0) hold_flag = ~hold_flag;
      wait_drained();
    end

    if (nearest_due.size() != 0) begin
      $display("%0t: %0d nearest sets never arrived", $time, nearest_due.size());
      mismatches++;
    end
    $display("Run took %0d items (%0d joint writes, %0d queries), %0d results checked.",
             items_in, writes_in, items_in - writes_in, results_got);
    $display("Joint counts 0 to 63 with ties, extremes and a long output hold-off.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
